### rtl/can_mailbox_table_scheduler_assert.svh
`ifndef CAN_MAILBOX_TABLE_SCHEDULER_ASSERT_SVH
`define CAN_MAILBOX_TABLE_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define CMTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cmts_pkg.sv
package cmts_pkg;

  localparam int INBOX_SLOTS  = 16;
  localparam int OUTBOX_SLOTS = 16;
  localparam int MAX_RESULTS  = 16;

  localparam int IB_IW  = (INBOX_SLOTS > 1) ? $clog2(INBOX_SLOTS) : 1;
  localparam int OB_IW  = (OUTBOX_SLOTS > 1) ? $clog2(OUTBOX_SLOTS) : 1;
  localparam int IDX_W  = (IB_IW > OB_IW) ? IB_IW : OB_IW;
  localparam int N_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [IDX_W-1:0] IB_LAST = IDX_W'(INBOX_SLOTS - 1);
  localparam logic [IDX_W-1:0] OB_LAST = IDX_W'(OUTBOX_SLOTS - 1);
  localparam logic [N_W-1:0]   N_MAX   = N_W'(MAX_RESULTS);

  localparam logic [28:0] STD_ID_MAX = 29'h7FF;

  typedef enum logic [2:0] {
    REQ_ADD_IB  = 3'd0,
    REQ_ADD_OB  = 3'd1,
    REQ_WR_OB   = 3'd2,
    REQ_RX      = 3'd3,
    REQ_TICK    = 3'd4,
    REQ_READ_IB = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_TX     = 2'd1,
    KIND_INBOX  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SRCH, S_CMP, S_TOB, S_TOB2, S_TDIV, S_TPUSH,
    S_TIB, S_TIB2, S_FINAL
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [28:0] can_id;
    logic [3:0]  byte_count;
    logic [63:0] payload;
    logic [31:0] time_value;
    logic [31:0] start_phase;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [28:0] out_id;
    logic        extended;
    logic [3:0]  out_count;
    logic [63:0] out_data;
    logic [1:0]  status;
    logic        recent;
    logic        timed_out;
    logic        last;
  } out_t;

  // flags: [5] recent, [4] timed out, [3:0] byte count
  typedef struct packed {
    logic [28:0] id;
    logic [31:0] limit;
    logic [31:0] age;
    logic [5:0]  flags;
    logic [63:0] bytes;
  } ib_entry_t;

  typedef struct packed {
    logic [28:0] id;
    logic [31:0] period;
    logic [31:0] timer;
    logic [3:0]  len;
    logic [63:0] bytes;
  } ob_entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [3:0] clamp_count(input logic [3:0] c);
    clamp_count = (c > 4'd8) ? 4'd0 : c;
  endfunction

  function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [3:0] c);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < c) m[k*8 +: 8] = 8'hFF;
    end
    keep_bytes = d & m;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### rtl/cmts_mod_unit.sv
// restoring remainder, one quotient bit per cycle
module cmts_mod_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  cmts_pkg::div_req_t  req,
  output cmts_pkg::div_rsp_t  rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    trial    = {rem_r[31:0], num_r[31]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = '0;
      num_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, den_r}) ? trial - {1'b0, den_r} : trial;
      num_nxt = {num_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[31:0];

endmodule

### rtl/can_mailbox_table_scheduler.sv
// channel   | handshake              | item
// in_       | in_valid / in_ready    | cmts_pkg::in_t request
// out_      | out_valid / out_ready  | cmts_pkg::out_t result, last marks final
//
// Add requests go through decode then final; lookups visit a search state per
// slot scanned and a compare state per valid one. A tick walks every outbox
// then every inbox: each slot visits a scan state, a used one an update state,
// and a due outbox the push state, via the remainder unit for nonzero period.
// Synchronous reset clears the table valid bits, not the table memories, which are not swept.
// Output stalls hold the walk; in_ready is high only between items.
module can_mailbox_table_scheduler (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cmts_pkg::in_t   in_payload,
  output logic            out_valid,
  input  logic            out_ready,
  output cmts_pkg::out_t  out_payload
);

  cmts_pkg::state_e state_r, state_nxt;
  logic [cmts_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [cmts_pkg::IDX_W-1:0] wr_idx;
  logic [cmts_pkg::N_W-1:0]   n_r, n_nxt;
  logic [1:0]                 st_r, st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cmts_pkg::out_t             out_r, out_nxt;
  logic                       pend_valid_r, pend_valid_nxt;
  cmts_pkg::out_t             pend_r, pend_nxt;
  logic [cmts_pkg::INBOX_SLOTS-1:0]  ib_valid_r, ib_valid_nxt;
  logic [cmts_pkg::OUTBOX_SLOTS-1:0] ob_valid_r, ob_valid_nxt;

  cmts_pkg::req_e type_r;
  logic [28:0]    id_r;
  logic [3:0]     cnt_r;
  logic [63:0]    data_r;
  logic [31:0]    tv_r;
  logic [31:0]    sp_r;

  cmts_pkg::ib_entry_t ib_mem [cmts_pkg::INBOX_SLOTS];
  cmts_pkg::ob_entry_t ob_mem [cmts_pkg::OUTBOX_SLOTS];
  cmts_pkg::ib_entry_t ib_rd_r, ib_wdata;
  cmts_pkg::ob_entry_t ob_rd_r, ob_wdata;
  logic ib_we, ob_we;

  cmts_pkg::div_req_t div_req;
  cmts_pkg::div_rsp_t div_rsp;

  logic        in_fire, emit_ok;
  logic [31:0] t_sum, age_sum;
  logic        ib_free_any, ob_free_any;
  logic [cmts_pkg::IDX_W-1:0] ib_free, ob_free;
  cmts_pkg::out_t frame;
  cmts_pkg::ib_entry_t ib_upd;

  cmts_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready    = (state_r == cmts_pkg::S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign emit_ok     = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  // lowest free slot
  always_comb begin
    ib_free_any = 1'b0;
    ib_free     = '0;
    for (int i = cmts_pkg::INBOX_SLOTS - 1; i >= 0; i--) begin
      if (!ib_valid_r[i]) begin
        ib_free_any = 1'b1;
        ib_free     = cmts_pkg::IDX_W'(i);
      end
    end
    ob_free_any = 1'b0;
    ob_free     = '0;
    for (int i = cmts_pkg::OUTBOX_SLOTS - 1; i >= 0; i--) begin
      if (!ob_valid_r[i]) begin
        ob_free_any = 1'b1;
        ob_free     = cmts_pkg::IDX_W'(i);
      end
    end
  end

  assign t_sum   = cmts_pkg::sat_add(ob_rd_r.timer, tv_r);
  assign age_sum = cmts_pkg::sat_add(ib_rd_r.age, tv_r);

  always_comb begin
    frame             = '0;
    frame.result_kind = cmts_pkg::KIND_TX;
    frame.out_id      = ob_rd_r.id;
    frame.extended    = ob_rd_r.id > cmts_pkg::STD_ID_MAX;
    frame.out_count   = ob_rd_r.len;
    frame.out_data    = ob_rd_r.bytes;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    wr_idx         = idx_r;
    n_nxt          = n_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    ib_valid_nxt   = ib_valid_r;
    ob_valid_nxt   = ob_valid_r;
    ib_we          = 1'b0;
    ob_we          = 1'b0;
    ib_wdata       = ib_rd_r;
    ob_wdata       = ob_rd_r;
    ib_upd         = ib_rd_r;
    div_req        = '{start: 1'b0, num: t_sum, den: ob_rd_r.period};

    unique case (state_r)
      cmts_pkg::S_IDLE: begin
        if (in_fire) state_nxt = cmts_pkg::S_DECODE;
      end

      cmts_pkg::S_DECODE: begin
        pend_valid_nxt = 1'b0;
        n_nxt          = '0;
        st_nxt         = cmts_pkg::ST_OK;
        state_nxt      = cmts_pkg::S_FINAL;
        unique case (type_r)
          cmts_pkg::REQ_ADD_IB: begin
            if (ib_free_any) begin
              ib_we    = 1'b1;
              idx_nxt  = ib_free;
              wr_idx   = ib_free;
              ib_wdata = '{id: id_r, limit: tv_r, age: '0, flags: '0, bytes: '0};
              ib_valid_nxt[ib_free[cmts_pkg::IB_IW-1:0]] = 1'b1;
            end else begin
              st_nxt = cmts_pkg::ST_FULL;
            end
          end
          cmts_pkg::REQ_ADD_OB: begin
            if (ob_free_any) begin
              ob_we    = 1'b1;
              idx_nxt  = ob_free;
              wr_idx   = ob_free;
              ob_wdata = '{id: id_r, period: tv_r, timer: sp_r, len: '0, bytes: '0};
              ob_valid_nxt[ob_free[cmts_pkg::OB_IW-1:0]] = 1'b1;
            end else begin
              st_nxt = cmts_pkg::ST_FULL;
            end
          end
          cmts_pkg::REQ_WR_OB: begin
            idx_nxt   = cmts_pkg::OB_LAST;
            state_nxt = cmts_pkg::S_SRCH;
          end
          cmts_pkg::REQ_RX, cmts_pkg::REQ_READ_IB: begin
            idx_nxt   = cmts_pkg::IB_LAST;
            state_nxt = cmts_pkg::S_SRCH;
          end
          cmts_pkg::REQ_TICK: begin
            idx_nxt   = '0;
            state_nxt = cmts_pkg::S_TOB;
          end
          default: st_nxt = cmts_pkg::ST_NOMATCH;
        endcase
      end

      // newest first: scan down, skipping empty slots
      cmts_pkg::S_SRCH: begin
        if ((type_r == cmts_pkg::REQ_WR_OB) ? ob_valid_r[idx_r[cmts_pkg::OB_IW-1:0]]
                                            : ib_valid_r[idx_r[cmts_pkg::IB_IW-1:0]]) begin
          state_nxt = cmts_pkg::S_CMP;
        end else if (idx_r == '0) begin
          st_nxt    = cmts_pkg::ST_NOMATCH;
          state_nxt = cmts_pkg::S_FINAL;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end

      cmts_pkg::S_CMP: begin
        if ((type_r == cmts_pkg::REQ_WR_OB) ? (ob_rd_r.id == id_r)
                                            : (ib_rd_r.id == id_r)) begin
          state_nxt = cmts_pkg::S_FINAL;
          if (type_r == cmts_pkg::REQ_WR_OB) begin
            ob_we          = 1'b1;
            ob_wdata.len   = cnt_r;
            ob_wdata.bytes = data_r;
          end else if (type_r == cmts_pkg::REQ_RX) begin
            ib_we          = 1'b1;
            ib_wdata.bytes = data_r;
            ib_wdata.age   = '0;
            ib_wdata.flags = {2'b10, cnt_r};
          end else begin
            pend_valid_nxt       = 1'b1;
            pend_nxt             = '0;
            pend_nxt.result_kind = cmts_pkg::KIND_INBOX;
            pend_nxt.out_id      = ib_rd_r.id;
            pend_nxt.extended    = ib_rd_r.id > cmts_pkg::STD_ID_MAX;
            pend_nxt.out_count   = ib_rd_r.flags[3:0];
            pend_nxt.out_data    = cmts_pkg::keep_bytes(ib_rd_r.bytes,
                                     cmts_pkg::clamp_count(ib_rd_r.flags[3:0]));
            pend_nxt.recent      = ib_rd_r.flags[5];
            pend_nxt.timed_out   = ib_rd_r.flags[4];
          end
        end else if (idx_r == '0) begin
          st_nxt    = cmts_pkg::ST_NOMATCH;
          state_nxt = cmts_pkg::S_FINAL;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = cmts_pkg::S_SRCH;
        end
      end

      cmts_pkg::S_TOB: begin
        if (ob_valid_r[idx_r[cmts_pkg::OB_IW-1:0]]) begin
          state_nxt = cmts_pkg::S_TOB2;
        end else if (idx_r == cmts_pkg::OB_LAST) begin
          idx_nxt   = '0;
          state_nxt = cmts_pkg::S_TIB;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      cmts_pkg::S_TOB2: begin
        if ((ob_rd_r.period == '0 || t_sum >= ob_rd_r.period) && n_r != cmts_pkg::N_MAX) begin
          if (ob_rd_r.period == '0) begin
            ob_we          = 1'b1;
            ob_wdata.timer = '0;
            state_nxt      = cmts_pkg::S_TPUSH;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = cmts_pkg::S_TDIV;
          end
        end else begin
          ob_we          = 1'b1;
          ob_wdata.timer = t_sum;
          if (idx_r == cmts_pkg::OB_LAST) begin
            idx_nxt   = '0;
            state_nxt = cmts_pkg::S_TIB;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = cmts_pkg::S_TOB;
          end
        end
      end

      cmts_pkg::S_TDIV: begin
        if (div_rsp.done) begin
          ob_we          = 1'b1;
          ob_wdata.timer = div_rsp.rem;
          state_nxt      = cmts_pkg::S_TPUSH;
        end
      end

      // one frame is held back so that the final one can carry last
      cmts_pkg::S_TPUSH: begin
        if (!pend_valid_r || emit_ok) begin
          if (pend_valid_r) begin
            out_nxt       = pend_r;
            out_valid_nxt = 1'b1;
          end
          pend_valid_nxt = 1'b1;
          pend_nxt       = frame;
          n_nxt          = n_r + 1'b1;
          if (idx_r == cmts_pkg::OB_LAST) begin
            idx_nxt   = '0;
            state_nxt = cmts_pkg::S_TIB;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = cmts_pkg::S_TOB;
          end
        end
      end

      cmts_pkg::S_TIB: begin
        if (ib_valid_r[idx_r[cmts_pkg::IB_IW-1:0]]) begin
          state_nxt = cmts_pkg::S_TIB2;
        end else if (idx_r == cmts_pkg::IB_LAST) begin
          state_nxt = cmts_pkg::S_FINAL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      cmts_pkg::S_TIB2: begin
        ib_upd.age = age_sum;
        if (ib_rd_r.limit != '0 && ib_rd_r.limit < age_sum) begin
          ib_upd.flags = {2'b01, ib_rd_r.flags[3:0]};
        end
        ib_we    = 1'b1;
        ib_wdata = ib_upd;
        if (idx_r == cmts_pkg::IB_LAST) begin
          state_nxt = cmts_pkg::S_FINAL;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = cmts_pkg::S_TIB;
        end
      end

      cmts_pkg::S_FINAL: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt        = '0;
            out_nxt.status = st_r;
            out_nxt.last   = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = cmts_pkg::S_IDLE;
        end
      end

      default: state_nxt = cmts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cmts_pkg::S_IDLE;
      idx_r        <= '0;
      n_r          <= '0;
      st_r         <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      ib_valid_r   <= '0;
      ob_valid_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      ib_valid_r   <= ib_valid_nxt;
      ob_valid_r   <= ob_valid_nxt;
    end
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
    if (in_fire) begin
      type_r <= cmts_pkg::req_e'(in_payload.req_type);
      id_r   <= in_payload.can_id;
      cnt_r  <= cmts_pkg::clamp_count(in_payload.byte_count);
      data_r <= cmts_pkg::keep_bytes(in_payload.payload,
                                     cmts_pkg::clamp_count(in_payload.byte_count));
      tv_r   <= in_payload.time_value;
      sp_r   <= in_payload.start_phase;
    end
  end

  // tables: read at the next index every cycle, written back at the write index
  always_ff @(posedge clk) begin
    if (ib_we) ib_mem[wr_idx[cmts_pkg::IB_IW-1:0]] <= ib_wdata;
    ib_rd_r <= ib_mem[idx_nxt[cmts_pkg::IB_IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ob_we) ob_mem[wr_idx[cmts_pkg::OB_IW-1:0]] <= ob_wdata;
    ob_rd_r <= ob_mem[idx_nxt[cmts_pkg::OB_IW-1:0]];
  end

endmodule

### rtl/cmts_checker.sv
`include "can_mailbox_table_scheduler_assert.svh"

module cmts_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input cmts_pkg::in_t   in_payload,
  input logic            out_valid,
  input logic            out_ready,
  input cmts_pkg::out_t  out_payload
);

  `CMTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "result item dropped or changed while stalled")
  `CMTS_ASSERT_IMP(a_status_clean, out_valid && out_payload.result_kind == cmts_pkg::KIND_STATUS, out_payload.out_id == '0 && out_payload.out_count == '0 && out_payload.out_data == '0 && out_payload.last, "status reply not clean")
  `CMTS_ASSERT_IMP(a_ext_flag, out_valid && out_payload.result_kind != cmts_pkg::KIND_STATUS, out_payload.extended == (out_payload.out_id > cmts_pkg::STD_ID_MAX), "extended flag mismatch")
  `CMTS_ASSERT_IMP(a_count_range, out_valid, out_payload.out_count <= 4'd8, "byte count above eight")
  `CMTS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item taken while previous item in progress")

endmodule

bind can_mailbox_table_scheduler cmts_checker u_cmts_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);

### tb/sv/can_mailbox_table_scheduler_tb.sv
module can_mailbox_table_scheduler_tb;
  import cmts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_payload;

  can_mailbox_table_scheduler u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_payload(in_payload), .out_valid(out_valid), .out_ready(out_ready),
    .out_payload(out_payload)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the mailbox tables
  logic        ib_used [INBOX_SLOTS];
  ib_entry_t   ib_tab  [INBOX_SLOTS];
  logic        ob_used [OUTBOX_SLOTS];
  ob_entry_t   ob_tab  [OUTBOX_SLOTS];

  in_t  pending_items[$];
  out_t expected_results[$];
  int   mismatches = 0;
  logic stim_done = 1'b0;
  logic hold_off = 1'b0;

  // id pool so lookups hit often
  logic [28:0] id_pool[8];

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [63:0] mask_bytes(logic [63:0] d, logic [3:0] c);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) if (k < c) m[k*8 +: 8] = 8'hFF;
    return d & m;
  endfunction

  function automatic out_t status_res(logic [1:0] st);
    out_t r;
    r = '0;
    r.result_kind = KIND_STATUS;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_mailbox(input in_t it);
    logic [3:0]  cnt;
    logic [63:0] dat;
    logic [31:0] t;
    out_t r;
    int hit, n;
    cnt = (it.byte_count > 4'd8) ? 4'd0 : it.byte_count;
    dat = mask_bytes(it.payload, cnt);
    hit = -1;
    n = 0;
    case (it.req_type)
      REQ_ADD_IB: begin
        for (int i = 0; i < INBOX_SLOTS; i++) if (hit < 0 && !ib_used[i]) hit = i;
        if (hit >= 0) begin
          ib_used[hit] = 1'b1;
          ib_tab[hit] = '{id: it.can_id, limit: it.time_value, age: '0, flags: '0,
                          bytes: '0};
        end
        expected_results.push_back(status_res(hit >= 0 ? ST_OK : ST_FULL));
      end
      REQ_ADD_OB: begin
        for (int i = 0; i < OUTBOX_SLOTS; i++) if (hit < 0 && !ob_used[i]) hit = i;
        if (hit >= 0) begin
          ob_used[hit] = 1'b1;
          ob_tab[hit] = '{id: it.can_id, period: it.time_value, timer: it.start_phase,
                          len: '0, bytes: '0};
        end
        expected_results.push_back(status_res(hit >= 0 ? ST_OK : ST_FULL));
      end
      REQ_WR_OB: begin
        for (int i = 0; i < OUTBOX_SLOTS; i++)
          if (ob_used[i] && ob_tab[i].id == it.can_id) hit = i;
        if (hit >= 0) begin
          ob_tab[hit].len = cnt;
          ob_tab[hit].bytes = dat;
        end
        expected_results.push_back(status_res(hit >= 0 ? ST_OK : ST_NOMATCH));
      end
      REQ_RX: begin
        for (int i = 0; i < INBOX_SLOTS; i++)
          if (ib_used[i] && ib_tab[i].id == it.can_id) hit = i;
        if (hit >= 0) begin
          ib_tab[hit].bytes = dat;
          ib_tab[hit].age = '0;
          ib_tab[hit].flags = {2'b10, cnt};
        end
        expected_results.push_back(status_res(hit >= 0 ? ST_OK : ST_NOMATCH));
      end
      REQ_TICK: begin
        for (int i = 0; i < OUTBOX_SLOTS; i++) begin
          if (ob_used[i]) begin
            t = add_sat(ob_tab[i].timer, it.time_value);
            if (ob_tab[i].period == 0 || t >= ob_tab[i].period) begin
              if (n >= MAX_RESULTS) ob_tab[i].timer = t;
              else begin
                ob_tab[i].timer = (ob_tab[i].period == 0) ? '0 : t % ob_tab[i].period;
                r = '0;
                r.result_kind = KIND_TX;
                r.out_id = ob_tab[i].id;
                r.extended = ob_tab[i].id > STD_ID_MAX;
                r.out_count = ob_tab[i].len;
                r.out_data = mask_bytes(ob_tab[i].bytes, ob_tab[i].len);
                expected_results.push_back(r);
                n++;
              end
            end else ob_tab[i].timer = t;
          end
        end
        for (int i = 0; i < INBOX_SLOTS; i++) begin
          if (ib_used[i]) begin
            ib_tab[i].age = add_sat(ib_tab[i].age, it.time_value);
            if (ib_tab[i].limit != 0 && ib_tab[i].limit < ib_tab[i].age)
              ib_tab[i].flags = {2'b01, ib_tab[i].flags[3:0]};
          end
        end
        if (n == 0) expected_results.push_back(status_res(ST_OK));
        else expected_results[$].last = 1'b1;
      end
      REQ_READ_IB: begin
        for (int i = 0; i < INBOX_SLOTS; i++)
          if (ib_used[i] && ib_tab[i].id == it.can_id) hit = i;
        if (hit >= 0) begin
          r = '0;
          r.result_kind = KIND_INBOX;
          r.out_id = ib_tab[hit].id;
          r.extended = ib_tab[hit].id > STD_ID_MAX;
          r.out_count = ib_tab[hit].flags[3:0];
          r.out_data = mask_bytes(ib_tab[hit].bytes,
                                  ib_tab[hit].flags[3:0] > 8 ? 4'd0 : ib_tab[hit].flags[3:0]);
          r.recent = ib_tab[hit].flags[5];
          r.timed_out = ib_tab[hit].flags[4];
          r.last = 1'b1;
          expected_results.push_back(r);
        end else expected_results.push_back(status_res(ST_NOMATCH));
      end
      default: expected_results.push_back(status_res(ST_NOMATCH));
    endcase
  endtask

  function automatic in_t make_item(logic [2:0] rt, logic [28:0] id, logic [3:0] bc,
                                    logic [63:0] pl, logic [31:0] tv, logic [31:0] sp);
    in_t it;
    it.req_type = rt; it.can_id = id; it.byte_count = bc;
    it.payload = pl; it.time_value = tv; it.start_phase = sp;
    return it;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // driver
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_mailbox(in_payload);
        if (pending_items.size() > 0 && drv_gap == 0 && $urandom_range(0, 3) != 0) begin
          in_payload <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
          drv_gap <= gap_len();
        end
      end else if (!in_valid) begin
        if (drv_gap > 0) drv_gap <= drv_gap - 1;
        else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_payload <= pending_items.pop_front();
        end
      end
    end
  end

  // monitor
  int rcv_gap = 0;
  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_payload);
        end else begin
          e = expected_results.pop_front();
          if (out_payload !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", e, out_payload);
          end
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else if (rcv_gap > 0) begin
        rcv_gap <= rcv_gap - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        rcv_gap <= gap_len();
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic logic [28:0] pick_id();
    return ($urandom_range(0, 7) != 0) ? id_pool[$urandom_range(0, 7)] : 29'($urandom());
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return 32'($urandom());
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return '0;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  initial begin
    logic [2:0] rt;
    for (int i = 0; i < INBOX_SLOTS; i++) ib_used[i] = 1'b0;
    for (int i = 0; i < OUTBOX_SLOTS; i++) ob_used[i] = 1'b0;
    id_pool = '{29'h000, 29'h7FF, 29'h800, 29'h1FFF_FFFF, 29'h123, 29'h0ABC_DEF0,
                29'h055, 29'h1000_0000};
    // directed: misses on empty tables, extremes, unknown requests
    pending_items.push_back(make_item(REQ_READ_IB, 29'h7FF, 4'd0, '0, '0, '0));
    pending_items.push_back(make_item(REQ_WR_OB, 29'h0, 4'd8, '1, '0, '0));
    pending_items.push_back(make_item(REQ_RX, 29'h800, 4'd8, '1, '0, '0));
    pending_items.push_back(make_item(REQ_TICK, 29'h0, 4'd0, '0, 32'd5, '0));
    pending_items.push_back(make_item(3'd6, 29'h1FFF_FFFF, 4'hF, '1, '1, '1));
    pending_items.push_back(make_item(3'd7, 29'h0, 4'd0, '0, '0, '0));
    pending_items.push_back(make_item(REQ_ADD_IB, 29'h7FF, 4'd0, '0, 32'd10, '0));
    pending_items.push_back(make_item(REQ_ADD_IB, 29'h1FFF_FFFF, 4'd0, '0, 32'd0, '0));
    pending_items.push_back(make_item(REQ_ADD_IB, 29'h7FF, 4'd0, '0, '1, '0));
    pending_items.push_back(make_item(REQ_ADD_OB, 29'h800, 4'd0, '0, 32'd0, '0));
    pending_items.push_back(make_item(REQ_ADD_OB, 29'h7FF, 4'd0, '0, 32'd7, 32'd6));
    pending_items.push_back(make_item(REQ_ADD_OB, 29'h1FFF_FFFF, 4'd0, '0, '1, '1));
    pending_items.push_back(make_item(REQ_WR_OB, 29'h800, 4'd9, '1, '0, '0));
    pending_items.push_back(make_item(REQ_WR_OB, 29'h7FF, 4'd3, 64'h0123_4567_89AB_CDEF,
                                      '0, '0));
    pending_items.push_back(make_item(REQ_WR_OB, 29'h1FFF_FFFF, 4'd8, '1, '0, '0));
    pending_items.push_back(make_item(REQ_RX, 29'h7FF, 4'd5, '1, '0, '0));
    pending_items.push_back(make_item(REQ_RX, 29'h1FFF_FFFF, 4'd15, '1, '0, '0));
    pending_items.push_back(make_item(REQ_READ_IB, 29'h7FF, 4'd0, '0, '0, '0));
    pending_items.push_back(make_item(REQ_TICK, 29'h0, 4'd0, '0, 32'd1, '0));
    pending_items.push_back(make_item(REQ_TICK, 29'h0, 4'd0, '0, '1, '0));
    pending_items.push_back(make_item(REQ_READ_IB, 29'h7FF, 4'd0, '0, '0, '0));
    pending_items.push_back(make_item(REQ_READ_IB, 29'h1FFF_FFFF, 4'd0, '0, '0, '0));
    pending_items.push_back(make_item(REQ_TICK, 29'h0, 4'd0, '0, 32'd3, '0));
    // random; add requests sparse so tables fill slowly and stay busy
    for (int k = 0; k < 360; k++) begin
      case ($urandom_range(0, 19))
        0, 1: rt = REQ_ADD_IB;
        2, 3: rt = REQ_ADD_OB;
        4, 5, 6: rt = REQ_WR_OB;
        7, 8, 9, 10: rt = REQ_RX;
        11, 12, 13, 14: rt = REQ_TICK;
        15, 16, 17, 18: rt = REQ_READ_IB;
        default: rt = 3'($urandom_range(6, 7));
      endcase
      pending_items.push_back(make_item(rt, pick_id(), 4'($urandom()),
                                        {$urandom(), $urandom()}, pick_time(),
                                        ($urandom_range(0, 3) == 0) ? 32'($urandom())
                                                                    : $urandom_range(0, 50)));
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_valid);
    stim_done = 1'b1;
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule
